>>> hdl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared constants, record codes and types of the greedy meshlet builder.
// ----------------------------------------------------------------------------
package gmb_pkg;

  localparam int VERTEX_SLOTS      = 4096;
  localparam int MAX_MESHLET_VERTS = 64;
  localparam int MAX_MESHLET_TRIS  = 126;
  localparam int PAD_MULTIPLE      = 32;

  localparam int VIDX_W = $clog2(VERTEX_SLOTS);
  localparam int SLOT_W = $clog2(MAX_MESHLET_VERTS);
  localparam int VCNT_W = 7;
  localparam int TCNT_W = 7;
  localparam int PAD_W  = $clog2(PAD_MULTIPLE);
  localparam int CFG_W  = 7;
  localparam int TBL_W  = SLOT_W + 1;   // {used, slot}

  localparam int VLIM_MIN = 3;
  localparam int TLIM_MIN = 1;

  typedef enum logic [1:0] {
    KIND_VERT  = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_PAD   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_VLIM = 1'b0,
    CFG_TLIM = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e               kind;
    logic [VIDX_W-1:0]   gv;
    logic [SLOT_W-1:0]   la;
    logic [SLOT_W-1:0]   lb;
    logic [SLOT_W-1:0]   lc;
    logic [VCNT_W-1:0]   vt;
    logic [TCNT_W-1:0]   tt;
    logic                last;
  } rec_t;

endpackage

>>> hdl/greedy_meshlet_builder.sv
// ----------------------------------------------------------------------------
// greedy_meshlet_builder
// Packs triangles greedily into meshlets and pads the meshlet count per mesh.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o   vertex_a/b/c_i, end_of_mesh_i
//   out      out        out_valid_o / out_stall_i rec_kind_o .. last_o
//
// A triangle goes through corner lookups, the limit check, vertex appends and
// its triangle word; a word that waits on a stalled output holds it. Closing a
// meshlet adds one slot table write per mark cleared, and then any pad words.
// After reset a sweep clears all 4096 slot table entries; in_stall_o is high.
// One triangle is worked on at a time; the output register lets the last
// word wait while the next triangle is taken.
// ----------------------------------------------------------------------------
module greedy_meshlet_builder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gmb_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_a_i,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_b_i,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_c_i,
  input  logic                       end_of_mesh_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 rec_kind_o,
  output logic [gmb_pkg::VIDX_W-1:0] global_vertex_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_a_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_b_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_c_o,
  output logic [gmb_pkg::VCNT_W-1:0] vert_total_o,
  output logic [gmb_pkg::TCNT_W-1:0] tri_total_o,
  output logic                       last_o
);
  import gmb_pkg::*;

  logic [CFG_W-1:0]  vlim_q, vlim_d, tlim_q, tlim_d;
  logic [VCNT_W-1:0] vlim;
  logic [TCNT_W-1:0] tlim;
  rec_t              rec;
  logic              rec_load, rec_ready;

  always_comb begin
    vlim_d = vlim_q;
    tlim_d = tlim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VLIM: vlim_d = cfg_wdata_i;
        CFG_TLIM: tlim_d = cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q <= CFG_W'(MAX_MESHLET_VERTS);
      tlim_q <= CFG_W'(MAX_MESHLET_TRIS);
    end else begin
      vlim_q <= vlim_d;
      tlim_q <= tlim_d;
    end
  end

  // out-of-range limits are clamped into the legal window
  always_comb begin
    if (vlim_q < CFG_W'(VLIM_MIN)) begin
      vlim = VCNT_W'(VLIM_MIN);
    end else if (vlim_q > CFG_W'(MAX_MESHLET_VERTS)) begin
      vlim = VCNT_W'(MAX_MESHLET_VERTS);
    end else begin
      vlim = VCNT_W'(vlim_q);
    end
    if (tlim_q < CFG_W'(TLIM_MIN)) begin
      tlim = TCNT_W'(TLIM_MIN);
    end else if (tlim_q > CFG_W'(MAX_MESHLET_TRIS)) begin
      tlim = TCNT_W'(MAX_MESHLET_TRIS);
    end else begin
      tlim = TCNT_W'(tlim_q);
    end
  end

  gmb_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vertex_a_i    (vertex_a_i),
    .vertex_b_i    (vertex_b_i),
    .vertex_c_i    (vertex_c_i),
    .end_of_mesh_i (end_of_mesh_i),
    .vlim_i        (vlim),
    .tlim_i        (tlim),
    .rec_o         (rec),
    .rec_load_o    (rec_load),
    .rec_ready_i   (rec_ready)
  );

  gmb_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_i           (rec),
    .rec_load_i      (rec_load),
    .rec_ready_o     (rec_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rec_kind_o      (rec_kind_o),
    .global_vertex_o (global_vertex_o),
    .local_a_o       (local_a_o),
    .local_b_o       (local_b_o),
    .local_c_o       (local_c_o),
    .vert_total_o    (vert_total_o),
    .tri_total_o     (tri_total_o),
    .last_o          (last_o)
  );

endmodule

>>> hdl/gmb_ram.sv
// ----------------------------------------------------------------------------
// gmb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/gmb_seq.sv
// ----------------------------------------------------------------------------
// gmb_seq
// Sequencer: looks up corners in the slot table, closes and clears meshlets,
// appends vertices and issues one record word at a time.
// ----------------------------------------------------------------------------
module gmb_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_a_i,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_b_i,
  input  logic [gmb_pkg::VIDX_W-1:0] vertex_c_i,
  input  logic                       end_of_mesh_i,
  input  logic [gmb_pkg::VCNT_W-1:0] vlim_i,
  input  logic [gmb_pkg::TCNT_W-1:0] tlim_i,
  output gmb_pkg::rec_t              rec_o,
  output logic                       rec_load_o,
  input  logic                       rec_ready_i
);
  import gmb_pkg::*;

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_LKA   = 14'b00000000000100,
    S_LKB   = 14'b00000000001000,
    S_LKC   = 14'b00000000010000,
    S_DEC   = 14'b00000000100000,
    S_TAKEA = 14'b00000001000000,
    S_TAKEB = 14'b00000010000000,
    S_TAKEC = 14'b00000100000000,
    S_TRI   = 14'b00001000000000,
    S_CLOSE = 14'b00010000000000,
    S_CLR   = 14'b00100000000000,
    S_CLRW  = 14'b01000000000000,
    S_PAD   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [VIDX_W-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic              end_q, end_d;
  logic              va_q, va_d, vb_q, vb_d, vc_q, vc_d;
  logic [SLOT_W-1:0] sa_q, sa_d, sb_q, sb_d, sc_q, sc_d;
  logic [VCNT_W-1:0] cnt_q, cnt_d;
  logic [TCNT_W-1:0] tri_q, tri_d;
  logic [PAD_W-1:0]  pad_q, pad_d, pad_inc;
  logic              fin_q, fin_d;
  logic [SLOT_W-1:0] j_q, j_d;
  logic              pend_q, pend_d;
  logic [VIDX_W-1:0] init_q, init_d;

  logic              tbl_we;
  logic [VIDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;
  logic              lst_we;
  logic [SLOT_W-1:0] lst_waddr, lst_raddr;
  logic [VIDX_W-1:0] lst_wdata, lst_rdata;

  logic [1:0]        fresh;
  logic [VCNT_W-1:0] need;
  logic              b_eq_a, c_eq_a, c_eq_b;
  logic              hit_b, hit_c;
  logic [SLOT_W-1:0] slot_b, slot_c;

  gmb_ram #(.WIDTH(TBL_W), .DEPTH(VERTEX_SLOTS)) u_slot_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  gmb_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_MESHLET_VERTS)) u_vert_list (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);

  assign pad_inc = (pad_q == PAD_W'(PAD_MULTIPLE - 1)) ? '0 : pad_q + 1'b1;
  assign fresh   = 2'({1'b0, ~va_q} + {1'b0, ~vb_q} + {1'b0, ~vc_q});
  assign need    = cnt_q + VCNT_W'(fresh);

  // later corners may hit a slot taken by an earlier corner of this triangle
  assign b_eq_a = (b_q == a_q);
  assign c_eq_a = (c_q == a_q);
  assign c_eq_b = (c_q == b_q);
  assign hit_b  = vb_q | b_eq_a;
  assign hit_c  = vc_q | c_eq_a | c_eq_b;
  assign slot_b = b_eq_a ? sa_q : sb_q;
  assign slot_c = c_eq_a ? sa_q : (c_eq_b ? sb_q : sc_q);

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; c_d = c_q; end_d = end_q;
    va_d = va_q; vb_d = vb_q; vc_d = vc_q;
    sa_d = sa_q; sb_d = sb_q; sc_d = sc_q;
    cnt_d = cnt_q; tri_d = tri_q; pad_d = pad_q; fin_d = fin_q;
    j_d = j_q; pend_d = pend_q; init_d = init_q;

    tbl_we    = 1'b0;
    tbl_waddr = init_q;
    tbl_wdata = '0;
    tbl_raddr = vertex_a_i;
    lst_we    = 1'b0;
    lst_waddr = cnt_q[SLOT_W-1:0];
    lst_wdata = a_q;
    lst_raddr = j_q;
    rec_o      = '0;
    rec_load_o = 1'b0;

    unique case (state_q)
      S_INIT: begin
        tbl_we = 1'b1;
        init_d = init_q + 1'b1;
        if (init_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          a_d = vertex_a_i; b_d = vertex_b_i; c_d = vertex_c_i;
          end_d = end_of_mesh_i;
          state_d = S_LKA;
        end
      end
      S_LKA: begin
        {va_d, sa_d} = tbl_rdata;
        tbl_raddr = b_q;
        state_d = S_LKB;
      end
      S_LKB: begin
        {vb_d, sb_d} = tbl_rdata;
        tbl_raddr = c_q;
        state_d = S_LKC;
      end
      S_LKC: begin
        {vc_d, sc_d} = tbl_rdata;
        state_d = S_DEC;
      end
      S_DEC: begin
        if (need > vlim_i || tri_q >= tlim_i) begin
          fin_d = 1'b0;
          state_d = S_CLOSE;
        end else begin
          state_d = S_TAKEA;
        end
      end
      S_CLOSE: begin
        rec_o.kind = KIND_CLOSE;
        rec_o.vt   = cnt_q;
        rec_o.tt   = tri_q;
        rec_o.last = fin_q && (pad_inc == '0);
        if (rec_ready_i) begin
          rec_load_o = 1'b1;
          pad_d  = pad_inc;
          j_d    = '0;
          pend_d = 1'b0;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        // read list entry j, clear the table entry read in the previous cycle
        pend_d = 1'b1;
        j_d    = j_q + 1'b1;
        if (pend_q) begin
          tbl_we    = 1'b1;
          tbl_waddr = lst_rdata;
        end
        if ({1'b0, j_q} == cnt_q - 1'b1) begin
          state_d = S_CLRW;
        end
      end
      S_CLRW: begin
        tbl_we    = 1'b1;
        tbl_waddr = lst_rdata;
        cnt_d = '0;
        tri_d = '0;
        if (fin_q) begin
          state_d = (pad_q != '0) ? S_PAD : S_IDLE;
        end else begin
          // table is empty now: every corner is unused
          va_d = 1'b0; vb_d = 1'b0; vc_d = 1'b0;
          state_d = S_TAKEA;
        end
      end
      S_TAKEA: begin
        if (va_q) begin
          state_d = S_TAKEB;
        end else begin
          rec_o.kind = KIND_VERT;
          rec_o.gv   = a_q;
          rec_o.la   = cnt_q[SLOT_W-1:0];
          if (rec_ready_i) begin
            rec_load_o = 1'b1;
            tbl_we = 1'b1; tbl_waddr = a_q; tbl_wdata = {1'b1, cnt_q[SLOT_W-1:0]};
            lst_we = 1'b1; lst_wdata = a_q;
            sa_d  = cnt_q[SLOT_W-1:0];
            cnt_d = cnt_q + 1'b1;
            state_d = S_TAKEB;
          end
        end
      end
      S_TAKEB: begin
        if (hit_b) begin
          sb_d = slot_b;
          state_d = S_TAKEC;
        end else begin
          rec_o.kind = KIND_VERT;
          rec_o.gv   = b_q;
          rec_o.la   = cnt_q[SLOT_W-1:0];
          if (rec_ready_i) begin
            rec_load_o = 1'b1;
            tbl_we = 1'b1; tbl_waddr = b_q; tbl_wdata = {1'b1, cnt_q[SLOT_W-1:0]};
            lst_we = 1'b1; lst_wdata = b_q;
            sb_d  = cnt_q[SLOT_W-1:0];
            cnt_d = cnt_q + 1'b1;
            state_d = S_TAKEC;
          end
        end
      end
      S_TAKEC: begin
        if (hit_c) begin
          sc_d = slot_c;
          state_d = S_TRI;
        end else begin
          rec_o.kind = KIND_VERT;
          rec_o.gv   = c_q;
          rec_o.la   = cnt_q[SLOT_W-1:0];
          if (rec_ready_i) begin
            rec_load_o = 1'b1;
            tbl_we = 1'b1; tbl_waddr = c_q; tbl_wdata = {1'b1, cnt_q[SLOT_W-1:0]};
            lst_we = 1'b1; lst_wdata = c_q;
            sc_d  = cnt_q[SLOT_W-1:0];
            cnt_d = cnt_q + 1'b1;
            state_d = S_TRI;
          end
        end
      end
      S_TRI: begin
        rec_o.kind = KIND_TRI;
        rec_o.la   = sa_q;
        rec_o.lb   = sb_q;
        rec_o.lc   = sc_q;
        rec_o.last = ~end_q;
        if (rec_ready_i) begin
          rec_load_o = 1'b1;
          tri_d = tri_q + 1'b1;
          if (end_q) begin
            fin_d = 1'b1;
            state_d = S_CLOSE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PAD: begin
        rec_o.kind = KIND_PAD;
        rec_o.last = (pad_inc == '0);
        if (rec_ready_i) begin
          rec_load_o = 1'b1;
          pad_d = pad_inc;
          if (pad_inc == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      tri_q   <= '0;
      pad_q   <= '0;
      fin_q   <= 1'b0;
      pend_q  <= 1'b0;
      j_q     <= '0;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tri_q   <= tri_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
      pend_q  <= pend_d;
      j_q     <= j_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; end_q <= end_d;
    va_q <= va_d; vb_q <= vb_d; vc_q <= vc_d;
    sa_q <= sa_d; sb_q <= sb_d; sc_q <= sc_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= VCNT_W'(MAX_MESHLET_VERTS))
    else $error("open vertex count above slot count");

  a_tri_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRI) |-> (cnt_q <= vlim_i && tri_q < tlim_i))
    else $error("triangle placed past a meshlet limit");

  a_clr_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLRW) |=> (cnt_q == '0 && tri_q == '0))
    else $error("counts not cleared after meshlet clear");

  a_mark_only_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we && tbl_wdata[TBL_W-1]) |->
      (state_q == S_TAKEA || state_q == S_TAKEB || state_q == S_TAKEC))
    else $error("slot marked outside vertex append");

  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD) |-> (pad_q != '0))
    else $error("padding with meshlet count already aligned");

endmodule

>>> hdl/gmb_out.sv
// ----------------------------------------------------------------------------
// gmb_out
// Output register: holds one record word until the consumer takes it.
// ----------------------------------------------------------------------------
module gmb_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gmb_pkg::rec_t              rec_i,
  input  logic                       rec_load_i,
  output logic                       rec_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 rec_kind_o,
  output logic [gmb_pkg::VIDX_W-1:0] global_vertex_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_a_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_b_o,
  output logic [gmb_pkg::SLOT_W-1:0] local_c_o,
  output logic [gmb_pkg::VCNT_W-1:0] vert_total_o,
  output logic [gmb_pkg::TCNT_W-1:0] tri_total_o,
  output logic                       last_o
);
  import gmb_pkg::*;

  logic valid_q, valid_d;
  rec_t rec_q;

  assign rec_ready_o = ~valid_q | ~out_stall_i;
  assign valid_d     = rec_ready_o ? rec_load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign rec_kind_o      = rec_q.kind;
  assign global_vertex_o = rec_q.gv;
  assign local_a_o       = rec_q.la;
  assign local_b_o       = rec_q.lb;
  assign local_c_o       = rec_q.lc;
  assign vert_total_o    = rec_q.vt;
  assign tri_total_o     = rec_q.tt;
  assign last_o          = rec_q.last;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy meshlet builder. A short table of
// triangles and limit writes runs first, then random meshes built from vertex
// neighborhoods, under several limit settings. Every output word is compared
// field by field against an in-bench packing predictor; both handshakes idle
// at random.
// ----------------------------------------------------------------------------
module tb_top;
  import gmb_pkg::*;

  localparam int IDLE_PCT      = 31;
  localparam int RANDOM_ITEMS  = 175;
  localparam int SETTLE_CYCLES = 150;   // covers a full clear burst
  localparam int MAX_PRINTS    = 100;
  localparam longint LIMIT_NS  = 64'd5_000_000;

  typedef enum bit {ROW_CFG, ROW_TRI} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_idx_e            sel;
    logic [CFG_W-1:0]    value;
    logic [VIDX_W-1:0]   a;
    logic [VIDX_W-1:0]   b;
    logic [VIDX_W-1:0]   c;
    logic                eom;
    bit                  typed;   // triangle slots typed in below
    logic [SLOT_W-1:0]   la;
    logic [SLOT_W-1:0]   lb;
    logic [SLOT_W-1:0]   lc;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_idx = CFG_VLIM;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VIDX_W-1:0]   vtx_a = '0;
  logic [VIDX_W-1:0]   vtx_b = '0;
  logic [VIDX_W-1:0]   vtx_c = '0;
  logic                eom = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          rec_kind;
  logic [VIDX_W-1:0]   global_vertex;
  logic [SLOT_W-1:0]   local_a;
  logic [SLOT_W-1:0]   local_b;
  logic [SLOT_W-1:0]   local_c;
  logic [VCNT_W-1:0]   vert_total;
  logic [TCNT_W-1:0]   tri_total;
  logic                last;

  int idle_pct = IDLE_PCT;
  int errors = 0;
  int words_seen = 0;
  int meshlets_seen = 0;
  int pads_seen = 0;
  int directed_items = 0;
  int random_items = 0;

  // packing predictor state
  bit                vtx_used [VERTEX_SLOTS];
  logic [SLOT_W-1:0] vtx_slot [VERTEX_SLOTS];
  logic [VIDX_W-1:0] open_list [MAX_MESHLET_VERTS];
  logic [VCNT_W-1:0] open_verts = '0;
  logic [TCNT_W-1:0] open_tris = '0;
  logic [PAD_W-1:0]  pad_phase = '0;
  logic [CFG_W-1:0]  vlim_reg = 7'd64;
  logic [CFG_W-1:0]  tlim_reg = 7'd126;

  rec_t step_recs [$];
  rec_t pending_recs [$];

  greedy_meshlet_builder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .vertex_a_i      (vtx_a),
    .vertex_b_i      (vtx_b),
    .vertex_c_i      (vtx_c),
    .end_of_mesh_i   (eom),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .rec_kind_o      (rec_kind),
    .global_vertex_o (global_vertex),
    .local_a_o       (local_a),
    .local_b_o       (local_b),
    .local_c_o       (local_c),
    .vert_total_o    (vert_total),
    .tri_total_o     (tri_total),
    .last_o          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout: %0d words still expected", pending_recs.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void seal_meshlet();
    rec_t r;
    r = '0;
    r.kind = KIND_CLOSE;
    r.vt = open_verts;
    r.tt = open_tris;
    step_recs.push_back(r);
    for (int j = 0; j < open_verts; j++) vtx_used[open_list[j]] = 1'b0;
    open_verts = '0;
    open_tris = '0;
    pad_phase = pad_phase + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] claim_slot(logic [VIDX_W-1:0] v);
    rec_t r;
    if (!vtx_used[v]) begin
      vtx_used[v] = 1'b1;
      vtx_slot[v] = open_verts[SLOT_W-1:0];
      open_list[open_verts[SLOT_W-1:0]] = v;
      r = '0;
      r.kind = KIND_VERT;
      r.gv = v;
      r.la = open_verts[SLOT_W-1:0];
      step_recs.push_back(r);
      open_verts = open_verts + 1'b1;
    end
    return vtx_slot[v];
  endfunction

  // words caused by one triangle, left in step_recs
  function automatic void pack_triangle(logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b,
                                        logic [VIDX_W-1:0] c, logic end_mesh);
    int vcap, tcap, fresh;
    rec_t r;
    step_recs.delete();
    vcap = (vlim_reg < VLIM_MIN) ? VLIM_MIN : int'(vlim_reg);
    if (vcap > MAX_MESHLET_VERTS) vcap = MAX_MESHLET_VERTS;
    tcap = (tlim_reg < TLIM_MIN) ? TLIM_MIN : int'(tlim_reg);
    if (tcap > MAX_MESHLET_TRIS) tcap = MAX_MESHLET_TRIS;
    // repeats of an unused corner each count here
    fresh = (vtx_used[a] ? 0 : 1) + (vtx_used[b] ? 0 : 1) + (vtx_used[c] ? 0 : 1);
    if (int'(open_verts) + fresh > vcap || int'(open_tris) >= tcap) seal_meshlet();
    r = '0;
    r.kind = KIND_TRI;
    r.la = claim_slot(a);
    r.lb = claim_slot(b);
    r.lc = claim_slot(c);
    step_recs.push_back(r);
    open_tris = open_tris + 1'b1;
    if (end_mesh) begin
      seal_meshlet();
      while (pad_phase != '0) begin
        r = '0;
        r.kind = KIND_PAD;
        step_recs.push_back(r);
        pad_phase = pad_phase + 1'b1;
      end
    end
    r = step_recs.pop_back();
    r.last = 1'b1;
    step_recs.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic plan_row_t cfg_row(cfg_idx_e sel, logic [CFG_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t tri_row(logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b,
                                        logic [VIDX_W-1:0] c, logic end_mesh, bit typed,
                                        logic [SLOT_W-1:0] la, logic [SLOT_W-1:0] lb,
                                        logic [SLOT_W-1:0] lc);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TRI;
    r.a = a;
    r.b = b;
    r.c = c;
    r.eom = end_mesh;
    r.typed = typed;
    r.la = la;
    r.lb = lb;
    r.lc = lc;
    return r;
  endfunction

  function automatic logic [VIDX_W-1:0] pick_corner(logic [VIDX_W-1:0] base, int span);
    if ($urandom_range(0, 19) == 0) return VIDX_W'($urandom_range(0, VERTEX_SLOTS - 1));
    return VIDX_W'(base + $urandom_range(0, span));
  endfunction

  task automatic send_triangle(plan_row_t row);
    rec_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    vtx_a <= row.a;
    vtx_b <= row.b;
    vtx_c <= row.c;
    eom <= row.eom;
    do @(posedge clk); while (in_stall);
    pack_triangle(row.a, row.b, row.c, row.eom);
    foreach (step_recs[i]) begin
      r = step_recs[i];
      if (row.typed && r.kind == KIND_TRI) begin
        r.la = row.la;
        r.lb = row.lb;
        r.lc = row.lc;
      end
      pending_recs.push_back(r);
    end
  endtask

  // park the input, wait out every expected word and the clear burst
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_limit(cfg_idx_e sel, logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_VLIM) vlim_reg = value;
    else tlim_reg = value;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch word %0d %s: got %0d want %0d", $time, words_seen, what,
               got, want);
  endtask

  task automatic check_word();
    rec_t want;
    if (pending_recs.size() == 0) begin
      report_mismatch("unexpected word, kind", int'(rec_kind), -1);
    end else begin
      want = pending_recs.pop_front();
      if (rec_kind !== want.kind)
        report_mismatch("rec_kind", int'(rec_kind), int'(want.kind));
      if (global_vertex !== want.gv)
        report_mismatch("global_vertex", int'(global_vertex), int'(want.gv));
      if (local_a !== want.la) report_mismatch("local_a", int'(local_a), int'(want.la));
      if (local_b !== want.lb) report_mismatch("local_b", int'(local_b), int'(want.lb));
      if (local_c !== want.lc) report_mismatch("local_c", int'(local_c), int'(want.lc));
      if (vert_total !== want.vt)
        report_mismatch("vert_total", int'(vert_total), int'(want.vt));
      if (tri_total !== want.tt)
        report_mismatch("tri_total", int'(tri_total), int'(want.tt));
      if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
    end
    if (rec_kind == KIND_CLOSE) meshlets_seen++;
    if (rec_kind == KIND_PAD) pads_seen++;
    words_seen++;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word();
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t row;
    logic [VIDX_W-1:0] base, a, b, c;
    logic end_mesh;
    int span, mesh_len, phase_items, ph;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits, corners at both ends, repeated corners
    plan.push_back(cfg_row(CFG_VLIM, 7'd64));
    plan.push_back(cfg_row(CFG_TLIM, 7'd126));
    plan.push_back(tri_row(12'd0, 12'd1, 12'd2, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd4095, 12'd4094, 12'd4093, 1'b0, 1'b1, 6'd3, 6'd4, 6'd5));
    plan.push_back(tri_row(12'd0, 12'd4095, 12'd1, 1'b0, 1'b1, 6'd0, 6'd3, 6'd1));
    plan.push_back(tri_row(12'd7, 12'd7, 12'd7, 1'b0, 1'b1, 6'd6, 6'd6, 6'd6));
    plan.push_back(tri_row(12'd8, 12'd8, 12'd0, 1'b0, 1'b1, 6'd7, 6'd7, 6'd0));
    plan.push_back(tri_row(12'hAAA, 12'h555, 12'd4095, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0));
    // end of mesh: close plus 31 pad words
    plan.push_back(tri_row(12'd9, 12'd10, 12'd11, 1'b1, 1'b1, 6'd10, 6'd11, 6'd12));
    // smallest limits: one triangle per meshlet
    plan.push_back(cfg_row(CFG_VLIM, 7'd3));
    plan.push_back(cfg_row(CFG_TLIM, 7'd1));
    plan.push_back(tri_row(12'd5, 12'd5, 12'd5, 1'b0, 1'b1, 6'd0, 6'd0, 6'd0));
    plan.push_back(tri_row(12'd5, 12'd6, 12'd7, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd0, 12'd0, 12'd1, 1'b0, 1'b1, 6'd0, 6'd0, 6'd1));
    // limits below range clamp up
    plan.push_back(cfg_row(CFG_VLIM, 7'd0));
    plan.push_back(cfg_row(CFG_TLIM, 7'd0));
    plan.push_back(tri_row(12'd1, 12'd2, 12'd3, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd3, 12'd3, 12'd4, 1'b1, 1'b1, 6'd0, 6'd0, 6'd1));
    // repeated unused corner counted twice forces an early close
    plan.push_back(cfg_row(CFG_VLIM, 7'd4));
    plan.push_back(cfg_row(CFG_TLIM, 7'd127));
    plan.push_back(tri_row(12'd1, 12'd2, 12'd3, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd9, 12'd9, 12'd1, 1'b0, 1'b1, 6'd0, 6'd0, 6'd1));
    plan.push_back(tri_row(12'd9, 12'd1, 12'd12, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd12, 12'd13, 12'd9, 1'b1, 1'b1, 6'd2, 6'd3, 6'd0));
    // vertex limit above range, triangle limit hit
    plan.push_back(cfg_row(CFG_VLIM, 7'd127));
    plan.push_back(cfg_row(CFG_TLIM, 7'd2));
    plan.push_back(tri_row(12'd100, 12'd200, 12'd300, 1'b0, 1'b1, 6'd0, 6'd1, 6'd2));
    plan.push_back(tri_row(12'd300, 12'd400, 12'd100, 1'b0, 1'b1, 6'd2, 6'd3, 6'd0));
    plan.push_back(tri_row(12'd4095, 12'd0, 12'd100, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        apply_limit(plan[i].sel, plan[i].value);
      end else begin
        send_triangle(plan[i]);
        directed_items++;
      end
    end

    // random meshes: mostly neighborhood corners so vertices get reused
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          apply_limit(CFG_VLIM, CFG_W'($urandom_range(3, 10)));
          apply_limit(CFG_TLIM, CFG_W'($urandom_range(1, 6)));
        end
        1: begin
          apply_limit(CFG_VLIM, CFG_W'($urandom_range(0, 127)));
          apply_limit(CFG_TLIM, CFG_W'($urandom_range(0, 127)));
        end
        default: begin
          apply_limit(CFG_VLIM, CFG_W'($urandom_range(20, 64)));
          apply_limit(CFG_TLIM, CFG_W'($urandom_range(10, 126)));
        end
      endcase
      idle_pct = (ph == 2) ? 0 : IDLE_PCT;   // one calm phase, no idling
      phase_items = 0;
      while (phase_items < 25) begin
        base = VIDX_W'($urandom_range(0, VERTEX_SLOTS - 1));
        span = $urandom_range(4, 40);
        mesh_len = $urandom_range(1, 24);
        for (int k = 0; k < mesh_len; k++) begin
          a = pick_corner(base, span);
          b = ($urandom_range(0, 11) == 0) ? a : pick_corner(base, span);
          c = ($urandom_range(0, 11) == 0) ? b : pick_corner(base, span);
          end_mesh = (k == mesh_len - 1) || ($urandom_range(0, 49) == 0);
          row = tri_row(a, b, c, end_mesh, 1'b0, '0, '0, '0);
          send_triangle(row);
          phase_items++;
          random_items++;
        end
      end
      ph++;
    end
    idle_pct = IDLE_PCT;

    drain_results();
    $display("covered %0d directed and %0d random triangles over %0d random limit phases",
             directed_items, random_items, ph);
    $display("checked %0d words: %0d meshlets closed, %0d pad words", words_seen,
             meshlets_seen, pads_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
